/* src/lwf_pkg.sv */
// Shared types, widths and command and status codes for the lock wait queue.
`timescale 1ns / 1ps
`default_nettype none

package lwf_pkg;

   localparam int DEPTH_DEFAULT = 16;

   localparam int SEQ_W  = 32;
   localparam int USER_W = 16;
   localparam int KIND_W = 8;
   localparam int CMD_W  = 2;
   localparam int STAT_W = 2;

   localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
   localparam logic [CMD_W-1:0] CMD_POP    = 2'd1;
   localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd2;

   localparam logic [STAT_W-1:0] STAT_DONE  = 2'd0;
   localparam logic [STAT_W-1:0] STAT_FULL  = 2'd1;
   localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd2;

   typedef struct packed {
      logic [SEQ_W-1:0]  seq;
      logic [USER_W-1:0] user;
      logic [KIND_W-1:0] kind;
   } entry_type;

endpackage

`default_nettype wire

/* src/lock_wait_fifo_with_match_removal.sv */
// Lock wait queue: circular buffer in one memory with pop and remove-matching compaction.
//
//   channel   direction   ports
//   req       in          req_valid, req_ready, req_cmd, req_seq_number, req_user_ident,
//                         req_lock_kind
//   rsp       out         rsp_valid, rsp_ready, rsp_status, rsp_head_seq, rsp_head_user,
//                         rsp_head_kind, rsp_removed_count, rsp_occupancy
//
// Insert, refused commands and the unused code answer at once; pop answers from the
// registered memory read. Remove-matching streams every queued entry through a compare
// on the memory's read port and writes survivors back on its write port, then answers.
// Reset is synchronous and empties the queue; memory contents are not cleared.
// A result waits in the output register; the next transaction is taken once it can move on.
`timescale 1ns / 1ps
`default_nettype none

module lock_wait_fifo_with_match_removal #(
   parameter int DEPTH = lwf_pkg::DEPTH_DEFAULT,
   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
   localparam int CNT_W = $clog2(DEPTH + 1)
) (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          req_valid,
   output logic                         req_ready,
   input  wire  [lwf_pkg::CMD_W-1:0]    req_cmd,
   input  wire  [lwf_pkg::SEQ_W-1:0]    req_seq_number,
   input  wire  [lwf_pkg::USER_W-1:0]   req_user_ident,
   input  wire  [lwf_pkg::KIND_W-1:0]   req_lock_kind,
   output logic                         rsp_valid,
   input  wire                          rsp_ready,
   output logic [lwf_pkg::STAT_W-1:0]   rsp_status,
   output logic [lwf_pkg::SEQ_W-1:0]    rsp_head_seq,
   output logic [lwf_pkg::USER_W-1:0]   rsp_head_user,
   output logic [lwf_pkg::KIND_W-1:0]   rsp_head_kind,
   output logic [CNT_W-1:0]             rsp_removed_count,
   output logic [CNT_W-1:0]             rsp_occupancy
);

   localparam logic [PTR_W:0]   DEPTH_P = (PTR_W + 1)'(DEPTH);
   localparam logic [CNT_W-1:0] FULL_C  = CNT_W'(DEPTH);

   typedef enum logic [1:0] {S_IDLE, S_POP, S_REM, S_REM_END} state_type;

   function automatic logic [PTR_W-1:0] wrap_add(input logic [PTR_W-1:0] base,
                                                 input logic [PTR_W-1:0] off);
      logic [PTR_W:0] sum;
      sum = {1'b0, base} + {1'b0, off};
      if (sum >= DEPTH_P) begin
         sum = sum - DEPTH_P;
      end
      return sum[PTR_W-1:0];
   endfunction

   state_type               state_ff, state_in;
   logic [CNT_W-1:0]        count_ff, count_in;
   logic [PTR_W-1:0]        head_ff, head_in;
   logic [PTR_W-1:0]        rd_idx_ff, rd_idx_in;
   logic [CNT_W-1:0]        w_ff, w_in;
   logic [CNT_W-1:0]        removed_ff, removed_in;
   lwf_pkg::entry_type      key_ff, key_in;

   logic                            rsp_valid_ff, rsp_valid_in;
   logic [lwf_pkg::STAT_W-1:0]      rsp_status_ff, rsp_status_in;
   lwf_pkg::entry_type              rsp_head_ff, rsp_head_in;
   logic [CNT_W-1:0]                rsp_removed_ff, rsp_removed_in;
   logic [CNT_W-1:0]                rsp_occ_ff, rsp_occ_in;

   lwf_pkg::entry_type      entry_mem [DEPTH];
   lwf_pkg::entry_type      rd_data_ff;
   lwf_pkg::entry_type      wr_data;
   logic                    rd_en, wr_en;
   logic [PTR_W-1:0]        rd_addr, wr_addr;

   lwf_pkg::entry_type      req_entry;
   logic                    rsp_free;
   logic                    match;

   assign req_entry = '{seq: req_seq_number, user: req_user_ident, kind: req_lock_kind};
   assign rsp_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == S_IDLE) && rsp_free;
   assign match     = (rd_data_ff == key_ff);

   always_comb begin
      state_in       = state_ff;
      count_in       = count_ff;
      head_in        = head_ff;
      rd_idx_in      = rd_idx_ff;
      w_in           = w_ff;
      removed_in     = removed_ff;
      key_in         = key_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_status_in  = rsp_status_ff;
      rsp_head_in    = rsp_head_ff;
      rsp_removed_in = rsp_removed_ff;
      rsp_occ_in     = rsp_occ_ff;
      rd_en          = 1'b0;
      rd_addr        = head_ff;
      wr_en          = 1'b0;
      wr_addr        = head_ff;
      wr_data        = req_entry;

      case (state_ff)
         S_IDLE: begin
            if (req_valid && req_ready) begin
               // Most commands answer at once; these are the common result fields.
               rsp_valid_in   = 1'b1;
               rsp_status_in  = lwf_pkg::STAT_DONE;
               rsp_head_in    = '0;
               rsp_removed_in = '0;
               rsp_occ_in     = count_ff;
               case (req_cmd)
                  lwf_pkg::CMD_INSERT: begin
                     if (count_ff == FULL_C) begin
                        rsp_status_in = lwf_pkg::STAT_FULL;
                     end else begin
                        wr_en      = 1'b1;
                        wr_addr    = wrap_add(head_ff, count_ff[PTR_W-1:0]);
                        count_in   = count_ff + 1'b1;
                        rsp_occ_in = count_ff + 1'b1;
                     end
                  end
                  lwf_pkg::CMD_POP: begin
                     if (count_ff == '0) begin
                        rsp_status_in = lwf_pkg::STAT_EMPTY;
                     end else begin
                        rsp_valid_in = 1'b0;
                        rd_en        = 1'b1;
                        state_in     = S_POP;
                     end
                  end
                  lwf_pkg::CMD_REMOVE: begin
                     if (count_ff != '0) begin
                        rsp_valid_in = 1'b0;
                        rd_en        = 1'b1;
                        key_in       = req_entry;
                        rd_idx_in    = '0;
                        w_in         = '0;
                        removed_in   = '0;
                        state_in     = S_REM;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_POP: begin
            if (rsp_free) begin
               rsp_valid_in   = 1'b1;
               rsp_status_in  = lwf_pkg::STAT_DONE;
               rsp_head_in    = rd_data_ff;
               rsp_removed_in = '0;
               rsp_occ_in     = count_ff - 1'b1;
               count_in       = count_ff - 1'b1;
               head_in        = wrap_add(head_ff, PTR_W'(1));
               state_in       = S_IDLE;
            end
         end
         S_REM: begin
            // Survivors are written back at the trailing write index, which never
            // passes the read index, so the next read always sees unmodified data.
            if (match) begin
               removed_in = removed_ff + 1'b1;
            end else begin
               wr_en   = 1'b1;
               wr_addr = wrap_add(head_ff, w_ff[PTR_W-1:0]);
               wr_data = rd_data_ff;
               w_in    = w_ff + 1'b1;
            end
            if ((CNT_W'(rd_idx_ff) + 1'b1) < count_ff) begin
               rd_en     = 1'b1;
               rd_addr   = wrap_add(head_ff, rd_idx_ff + 1'b1);
               rd_idx_in = rd_idx_ff + 1'b1;
            end else begin
               state_in = S_REM_END;
            end
         end
         S_REM_END: begin
            if (rsp_free) begin
               rsp_valid_in   = 1'b1;
               rsp_status_in  = lwf_pkg::STAT_DONE;
               rsp_head_in    = '0;
               rsp_removed_in = removed_ff;
               rsp_occ_in     = w_ff;
               count_in       = w_ff;
               state_in       = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         head_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         head_ff      <= head_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rd_idx_ff      <= rd_idx_in;
      w_ff           <= w_in;
      removed_ff     <= removed_in;
      key_ff         <= key_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_head_ff    <= rsp_head_in;
      rsp_removed_ff <= rsp_removed_in;
      rsp_occ_ff     <= rsp_occ_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         entry_mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= entry_mem[rd_addr];
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_head_seq      = rsp_head_ff.seq;
   assign rsp_head_user     = rsp_head_ff.user;
   assign rsp_head_kind     = rsp_head_ff.kind;
   assign rsp_removed_count = rsp_removed_ff;
   assign rsp_occupancy     = rsp_occ_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FULL_C)
      else $error("queue occupancy exceeds its depth");

   a_write_trails_read: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_REM) |-> (w_ff <= CNT_W'(rd_idx_ff)))
      else $error("compaction write index overtook the read index");

   a_walk_accounts: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_REM_END) |->
         ((CNT_W + 1)'(removed_ff) + (CNT_W + 1)'(w_ff) == (CNT_W + 1)'(count_ff)))
      else $error("removed and kept entries do not add up to the occupancy");

   a_insert_grows: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_cmd == lwf_pkg::CMD_INSERT && count_ff != FULL_C)
         |=> (count_ff == $past(count_ff) + 1'b1))
      else $error("accepted insert did not grow the queue");

endmodule

`default_nettype wire
